/* hw/rtl/vss_pkg.sv */
// Shared types, constants and the half-step coil table for the valve stepper sequencer.
// No dependencies; used by vss_step_logic and valve_stepper_sequencer.

package vss_pkg;

    localparam int unsigned STEP_W       = 10;
    localparam int unsigned PHASE_W      = 3;
    localparam int unsigned COIL_W       = 4;
    localparam int unsigned BLINK_W      = 8;
    localparam int unsigned BLINK_CNT_W  = 4;

    localparam int unsigned TRAVEL_RESET  = 420;
    localparam int unsigned HOMING_TRAVEL = 450;

    localparam logic [BLINK_W-1:0]     BLINK_ACTIVE = 8'hff;
    localparam logic [BLINK_W-1:0]     BLINK_DONE   = 8'h01;
    localparam logic [BLINK_W-1:0]     BLINK_FAIL   = 8'h55;
    localparam logic [BLINK_CNT_W-1:0] BLINK_LONG   = 4'd8;
    localparam logic [BLINK_CNT_W-1:0] BLINK_SHORT  = 4'd2;

    localparam logic [COIL_W-1:0] COIL_N = 4'h8;
    localparam logic [COIL_W-1:0] COIL_W_ = 4'h4;
    localparam logic [COIL_W-1:0] COIL_S = 4'h2;
    localparam logic [COIL_W-1:0] COIL_E = 4'h1;
    localparam logic [COIL_W-1:0] COIL_OFF = 4'h0;

    typedef enum logic [1:0] {
        OP_MOTOR_TICK = 2'd0,
        OP_LED_TICK   = 2'd1,
        OP_VALVE_CMD  = 2'd2,
        OP_MEAS       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        DIR_IDLE  = 2'd0,
        DIR_OPEN  = 2'd1,
        DIR_CLOSE = 2'd2
    } t_dir;

    typedef struct packed {
        t_dir                   dir;
        logic [STEP_W-1:0]      steps_left;
        logic [PHASE_W-1:0]     phase;
        logic [COIL_W-1:0]      coil_latch;
        logic                   valve_state;
        logic                   valid_flag;
        logic [BLINK_W-1:0]     blink_pattern;
        logic [BLINK_CNT_W-1:0] blink_left;
        logic                   led_level;
    } t_state;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              led;
        logic              valve_open;
        logic              data_valid;
        logic              moving;
        logic              report_due;
    } t_result;

    function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] coils;
        case (phase)
            3'd0:    coils = COIL_N;
            3'd1:    coils = COIL_N | COIL_E;
            3'd2:    coils = COIL_E;
            3'd3:    coils = COIL_E | COIL_S;
            3'd4:    coils = COIL_S;
            3'd5:    coils = COIL_S | COIL_W_;
            3'd6:    coils = COIL_W_;
            3'd7:    coils = COIL_W_ | COIL_N;
            default: coils = COIL_OFF;
        endcase
        return coils;
    endfunction

endpackage

/* hw/rtl/valve_stepper_sequencer.sv */
// Top level of the valve stepper sequencer: state registers, travel register, result register.
// Depends on vss_pkg and vss_step_logic.
//
// Usage: each input transaction carries an op (motor tick, LED tick, valve command or
// measurement outcome) plus its flags, and produces exactly one result transaction with
// the coil drive, LED level, stored valve position, data-valid flag, moving flag and a
// one-shot report_due. Input and output both use valid/stall handshakes.
// A transaction's result is registered and shows in the cycle after it is accepted.
// Throughput is one transaction per cycle unless the receiver stalls; the single result
// register is refilled in the same cycle it is drained, so o_in_stall rises only while a
// result waits and i_out_stall is high. The travel register (i_cfg_we/i_cfg_data) must be
// written only when no transaction is in flight; the block itself does not enforce this.
// Reset (synchronous, active low) empties the result register, loads the travel register
// with 420 half-steps and starts a homing close run of HOMING_TRAVEL half-steps that
// proceeds with the motor ticks that follow. While the receiver stalls, the pending result
// holds and input is stalled.

module valve_stepper_sequencer #(
    parameter int unsigned HOMING_TRAVEL = vss_pkg::HOMING_TRAVEL
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vss_pkg::STEP_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_op,
    input  logic                               i_open_request,
    input  logic                               i_close_request,
    input  logic                               i_force_move,
    input  logic                               i_meas_ok,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [vss_pkg::COIL_W-1:0]         o_coils,
    output logic                               o_led,
    output logic                               o_valve_open,
    output logic                               o_data_valid,
    output logic                               o_moving,
    output logic                               o_report_due
);

    vss_pkg::t_state                 r_state;
    vss_pkg::t_state                 n_state;
    vss_pkg::t_state                 reset_state;
    vss_pkg::t_result                r_result;
    vss_pkg::t_result                n_result;
    logic                            r_out_valid;
    logic [vss_pkg::STEP_W-1:0]      r_travel;
    logic                            in_accept;
    logic                            out_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;

    always_comb begin
        reset_state.dir           = vss_pkg::DIR_CLOSE;
        reset_state.steps_left    = HOMING_TRAVEL[vss_pkg::STEP_W-1:0];
        reset_state.phase         = '0;
        reset_state.coil_latch    = vss_pkg::COIL_OFF;
        reset_state.valve_state   = 1'b0;
        reset_state.valid_flag    = 1'b0;
        reset_state.blink_pattern = vss_pkg::BLINK_ACTIVE;
        reset_state.blink_left    = vss_pkg::BLINK_LONG;
        reset_state.led_level     = 1'b1;
    end

    vss_step_logic u_step (
        .i_state         (r_state),
        .i_travel        (r_travel),
        .i_op            (i_op),
        .i_open_request  (i_open_request),
        .i_close_request (i_close_request),
        .i_force_move    (i_force_move),
        .i_meas_ok       (i_meas_ok),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= reset_state;
            r_travel    <= vss_pkg::TRAVEL_RESET[vss_pkg::STEP_W-1:0];
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_travel <= i_cfg_data;
            end
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload register: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_coils      = r_result.coils;
    assign o_led        = r_result.led;
    assign o_valve_open = r_result.valve_open;
    assign o_data_valid = r_result.data_valid;
    assign o_moving     = r_result.moving;
    assign o_report_due = r_result.report_due;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_idle_tick_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_op == vss_pkg::OP_MOTOR_TICK && r_state.dir == vss_pkg::DIR_IDLE)
        |=> ($stable(r_state.steps_left) && $stable(r_state.coil_latch)))
        else $error("motor tick while idle changed run state");

    a_run_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_op == vss_pkg::OP_MOTOR_TICK &&
         (r_state.dir == vss_pkg::DIR_OPEN || r_state.dir == vss_pkg::DIR_CLOSE) &&
         r_state.steps_left == '0)
        |=> (o_coils == vss_pkg::COIL_OFF && !o_moving && o_report_due))
        else $error("run end did not de-energize and report");
`endif

endmodule

/* hw/rtl/vss_step_logic.sv */
// Next-state and result logic for one transaction of the valve stepper sequencer.
// Purely combinational; depends on vss_pkg.

module vss_step_logic (
    input  vss_pkg::t_state                 i_state,
    input  logic [vss_pkg::STEP_W-1:0]      i_travel,
    input  logic [1:0]                      i_op,
    input  logic                            i_open_request,
    input  logic                            i_close_request,
    input  logic                            i_force_move,
    input  logic                            i_meas_ok,
    output vss_pkg::t_state                 o_state,
    output vss_pkg::t_result                o_result
);

    logic report;
    logic run_active;

    assign run_active = (i_state.dir == vss_pkg::DIR_OPEN) ||
                        (i_state.dir == vss_pkg::DIR_CLOSE);

    always_comb begin
        o_state = i_state;
        report  = 1'b0;
        case (vss_pkg::t_op'(i_op))
            vss_pkg::OP_MOTOR_TICK: begin
                if (run_active) begin
                    if (i_state.steps_left == '0) begin
                        // end of run: de-energize and store the final position
                        o_state.valve_state   = (i_state.dir == vss_pkg::DIR_OPEN);
                        o_state.dir           = vss_pkg::DIR_IDLE;
                        o_state.coil_latch    = vss_pkg::COIL_OFF;
                        o_state.blink_pattern = vss_pkg::BLINK_DONE;
                        o_state.blink_left    = vss_pkg::BLINK_SHORT;
                        report                = 1'b1;
                    end else begin
                        o_state.coil_latch    = vss_pkg::half_step(i_state.phase);
                        o_state.steps_left    = i_state.steps_left - 1'b1;
                        if (i_state.dir == vss_pkg::DIR_OPEN) begin
                            o_state.phase = i_state.phase + 1'b1;
                        end else begin
                            o_state.phase = i_state.phase - 1'b1;
                        end
                        o_state.blink_pattern = vss_pkg::BLINK_ACTIVE;
                        o_state.blink_left    = vss_pkg::BLINK_LONG;
                    end
                end else begin
                    o_state.dir = vss_pkg::DIR_IDLE;
                end
            end
            vss_pkg::OP_LED_TICK: begin
                if (i_state.blink_left != '0) begin
                    o_state.led_level     = i_state.blink_pattern[0];
                    o_state.blink_left    = i_state.blink_left - 1'b1;
                    o_state.blink_pattern = i_state.blink_pattern >> 1;
                end else begin
                    o_state.led_level = 1'b0;
                end
            end
            vss_pkg::OP_VALVE_CMD: begin
                // a new run restarts the count; phase is kept
                if (i_open_request) begin
                    if (i_force_move || !i_state.valve_state) begin
                        o_state.dir        = vss_pkg::DIR_OPEN;
                        o_state.steps_left = i_travel;
                    end
                end else if (i_close_request) begin
                    if (i_force_move || i_state.valve_state) begin
                        o_state.dir        = vss_pkg::DIR_CLOSE;
                        o_state.steps_left = i_travel;
                    end
                end
            end
            vss_pkg::OP_MEAS: begin
                if (i_meas_ok) begin
                    o_state.blink_pattern = vss_pkg::BLINK_DONE;
                    o_state.blink_left    = vss_pkg::BLINK_SHORT;
                    o_state.valid_flag    = 1'b1;
                    report                = 1'b1;
                end else begin
                    o_state.blink_pattern = vss_pkg::BLINK_FAIL;
                    o_state.blink_left    = vss_pkg::BLINK_LONG;
                    o_state.valid_flag    = 1'b0;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    always_comb begin
        o_result.coils      = o_state.coil_latch;
        o_result.led        = o_state.led_level;
        o_result.valve_open = o_state.valve_state;
        o_result.data_valid = o_state.valid_flag;
        o_result.moving     = (o_state.dir == vss_pkg::DIR_OPEN) ||
                              (o_state.dir == vss_pkg::DIR_CLOSE);
        o_result.report_due = report;
    end

endmodule

/* bench/tb_valve_stepper_sequencer.sv */
// Self-checking bench for valve_stepper_sequencer: directed table, then random phases.
// Every transaction is checked, typed table rows against their listed result, all others against a cycle-free model.
// Depends on vss_pkg and the RTL under hw/rtl.

module tb_valve_stepper_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import vss_pkg::*;

    typedef enum logic {
        ROW_ITEM,
        ROW_TRAVEL
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_op               op;
        logic              open_req;
        logic              close_req;
        logic              forced;
        logic              meas_good;
        logic [STEP_W-1:0] travel;
        bit                typed;
        t_result           result;
    } t_stim_row;

    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 260;
    localparam int MAX_REPORTED    = 10;

    // Half-step coil sequence, phase 0 in the low nibble.
    localparam logic [31:0] COIL_SEQ = {
        COIL_W_ | COIL_N, COIL_W_, COIL_S | COIL_W_, COIL_S,
        COIL_E | COIL_S, COIL_E, COIL_N | COIL_E, COIL_N
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [STEP_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_op = OP_LED_TICK;
    logic              i_open_request = 1'b0;
    logic              i_close_request = 1'b0;
    logic              i_force_move = 1'b0;
    logic              i_meas_ok = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [COIL_W-1:0] o_coils;
    logic              o_led;
    logic              o_valve_open;
    logic              o_data_valid;
    logic              o_moving;
    logic              o_report_due;

    // Model state of the sequencer
    t_dir                   run_dir;
    logic [STEP_W-1:0]      steps_left;
    logic [PHASE_W-1:0]     phase_idx;
    logic [COIL_W-1:0]      coil_latch;
    logic                   valve_is_open;
    logic                   valid_flag;
    logic [BLINK_W-1:0]     blink_pattern;
    logic [BLINK_CNT_W-1:0] blink_left;
    logic                   led_level;
    logic [STEP_W-1:0]      travel_steps;

    t_result   pending_status[$];
    t_stim_row directed_rows[$];

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned unexpected_count = 0;
    int unsigned results_checked = 0;
    int unsigned items_sent = 0;
    int unsigned travel_writes = 0;

    logic [STEP_W-1:0] travel_plan [0:RANDOM_PHASES-1] = '{1, 1023, 0, 7, 20, 420, 3};

    valve_stepper_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_open_request  (i_open_request),
        .i_close_request (i_close_request),
        .i_force_move    (i_force_move),
        .i_meas_ok       (i_meas_ok),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_coils         (o_coils),
        .o_led           (o_led),
        .o_valve_open    (o_valve_open),
        .o_data_valid    (o_data_valid),
        .o_moving        (o_moving),
        .o_report_due    (o_report_due)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_stim_row op_row(input t_op op, input logic want_open,
                                         input logic want_close, input logic forced,
                                         input logic meas_good);
        t_stim_row row;
        row = '{kind: ROW_ITEM, op: op, open_req: want_open, close_req: want_close,
                forced: forced, meas_good: meas_good, travel: '0, typed: 1'b0,
                result: '0};
        return row;
    endfunction

    function automatic t_stim_row typed_row(input t_op op, input logic meas_good,
                                            input t_result result);
        t_stim_row row;
        row = op_row(op, 1'b0, 1'b0, 1'b0, meas_good);
        row.typed = 1'b1;
        row.result = result;
        return row;
    endfunction

    function automatic t_stim_row travel_row(input logic [STEP_W-1:0] travel);
        t_stim_row row;
        row = op_row(OP_LED_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        row.kind = ROW_TRAVEL;
        row.travel = travel;
        return row;
    endfunction

    // Advance the sequencer model by one transaction and return its status.
    task automatic step_valve(input t_op op, input logic want_open, input logic want_close,
                              input logic forced, input logic meas_good,
                              output t_result res);
        logic report;
        report = 1'b0;
        case (op)
            OP_MOTOR_TICK: begin
                if (run_dir == DIR_OPEN || run_dir == DIR_CLOSE) begin
                    if (steps_left == '0) begin
                        valve_is_open = (run_dir == DIR_OPEN);
                        report = 1'b1;
                        run_dir = DIR_IDLE;
                        coil_latch = COIL_OFF;
                        blink_pattern = BLINK_DONE;
                        blink_left = BLINK_SHORT;
                    end else begin
                        coil_latch = COIL_SEQ[{phase_idx, 2'b00} +: COIL_W];
                        steps_left = steps_left - 1'b1;
                        if (run_dir == DIR_OPEN)
                            phase_idx = phase_idx + 1'b1;
                        else
                            phase_idx = phase_idx - 1'b1;
                        blink_pattern = BLINK_ACTIVE;
                        blink_left = BLINK_LONG;
                    end
                end else begin
                    run_dir = DIR_IDLE;
                end
            end
            OP_LED_TICK: begin
                if (blink_left != '0) begin
                    led_level = blink_pattern[0];
                    blink_left = blink_left - 1'b1;
                    blink_pattern = blink_pattern >> 1;
                end else begin
                    led_level = 1'b0;
                end
            end
            OP_VALVE_CMD: begin
                // Open wins over close; an unforced command for the held state is dropped.
                if (want_open) begin
                    if (forced || !valve_is_open) begin
                        run_dir = DIR_OPEN;
                        steps_left = travel_steps;
                    end
                end else if (want_close) begin
                    if (forced || valve_is_open) begin
                        run_dir = DIR_CLOSE;
                        steps_left = travel_steps;
                    end
                end
            end
            default: begin
                if (meas_good) begin
                    blink_pattern = BLINK_DONE;
                    blink_left = BLINK_SHORT;
                    valid_flag = 1'b1;
                    report = 1'b1;
                end else begin
                    blink_pattern = BLINK_FAIL;
                    blink_left = BLINK_LONG;
                    valid_flag = 1'b0;
                end
            end
        endcase
        res.coils = coil_latch;
        res.led = led_level;
        res.valve_open = valve_is_open;
        res.data_valid = valid_flag;
        res.moving = (run_dir == DIR_OPEN || run_dir == DIR_CLOSE);
        res.report_due = report;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin sender_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    endtask

    // Sample the status queue away from the clock edge; return on a rising edge.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_status.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_item(input t_op op, input logic want_open, input logic want_close,
                             input logic forced, input logic meas_good, input bit hold,
                             input bit typed, input t_result typed_res);
        t_result res;
        if (hold || $urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < sender_idle_pct)
                @(posedge i_clk);
            if (hold)
                wait_drained();
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_open_request <= want_open;
        i_close_request <= want_close;
        i_force_move <= forced;
        i_meas_ok <= meas_good;
        do
            @(posedge i_clk);
        while (o_in_stall);
        step_valve(op, want_open, want_close, forced, meas_good, res);
        pending_status.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    task automatic write_travel(input logic [STEP_W-1:0] travel);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= travel;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        travel_steps = travel;
        travel_writes++;
    endtask

    always @(posedge i_clk) begin : status_monitor
        t_result want;
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{coils: o_coils, led: o_led, valve_open: o_valve_open,
                    data_valid: o_data_valid, moving: o_moving, report_due: o_report_due};
            if (pending_status.size() == 0) begin
                unexpected_count++;
                $display("Unexpected status transaction: %p", got);
            end else begin
                want = pending_status.pop_front();
                results_checked++;
                if (got.coils !== want.coils || got.led !== want.led ||
                    got.valve_open !== want.valve_open ||
                    got.data_valid !== want.data_valid ||
                    got.moving !== want.moving || got.report_due !== want.report_due) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("Mismatch at %0t: coils %h/%h led %b/%b open %b/%b valid %b/%b moving %b/%b report %b/%b (expected/actual)",
                                 $realtime, want.coils, got.coils, want.led, got.led,
                                 want.valve_open, got.valve_open, want.data_valid,
                                 got.data_valid, want.moving, got.moving,
                                 want.report_due, got.report_due);
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin : stimulus
        int unsigned roll;
        int unsigned total_errors;
        t_op op;
        logic [STEP_W-1:0] travel;

        // State after reset: homing close run pending, LED pattern all ones.
        travel_steps = STEP_W'(TRAVEL_RESET);
        run_dir = DIR_CLOSE;
        steps_left = STEP_W'(HOMING_TRAVEL);
        phase_idx = '0;
        coil_latch = COIL_OFF;
        valve_is_open = 1'b0;
        valid_flag = 1'b0;
        blink_pattern = BLINK_ACTIVE;
        blink_left = BLINK_LONG;
        led_level = 1'b1;

        directed_rows.push_back(typed_row(OP_LED_TICK, 1'b0,
            t_result'({COIL_OFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0})));
        directed_rows.push_back(typed_row(OP_MEAS, 1'b1,
            t_result'({COIL_OFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1})));
        directed_rows.push_back(typed_row(OP_MEAS, 1'b0,
            t_result'({COIL_OFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0})));
        directed_rows.push_back(typed_row(OP_MOTOR_TICK, 1'b0,
            t_result'({COIL_N, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0})));
        directed_rows.push_back(typed_row(OP_MOTOR_TICK, 1'b0,
            t_result'({COIL_W_ | COIL_N, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0})));
        // Open with the reset travel, replacing the homing run
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b1, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(travel_row(1));
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b0, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b0, 1'b1, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b0, 1'b0, 1'b1, 1'b1));
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b1, 1'b1, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b1, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b0, 1'b1, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        // Reverse mid-run: count restarts, phase is kept
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b1, 1'b0, 1'b1, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        // Zero travel ends the run on the first motor tick
        directed_rows.push_back(travel_row(0));
        directed_rows.push_back(op_row(OP_VALVE_CMD, 1'b1, 1'b0, 1'b1, 1'b0));
        directed_rows.push_back(op_row(OP_MOTOR_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(travel_row(1023));
        // Run the short blink out and tick past its end
        directed_rows.push_back(op_row(OP_LED_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_LED_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(op_row(OP_LED_TICK, 1'b0, 1'b0, 1'b0, 1'b0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idle_mode(0);
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_TRAVEL)
                write_travel(directed_rows[i].travel);
            else
                send_item(directed_rows[i].op, directed_rows[i].open_req,
                          directed_rows[i].close_req, directed_rows[i].forced,
                          directed_rows[i].meas_good, 1'b0, directed_rows[i].typed,
                          directed_rows[i].result);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            travel = (p == 4) ? STEP_W'($urandom_range(2, 40)) : travel_plan[p];
            write_travel(travel);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 130 == 0)
                    set_idle_mode((2 * p + k / 130) % 4);
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    op = OP_MOTOR_TICK;
                else if (roll < 65)
                    op = OP_LED_TICK;
                else if (roll < 85)
                    op = OP_VALVE_CMD;
                else
                    op = OP_MEAS;
                send_item(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 9) < 3), 1'($urandom_range(0, 1)),
                          (k == 60 || $urandom_range(0, 99) == 0), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);

        total_errors = mismatch_count + unexpected_count + pending_status.size();
        $display("Checked %0d status transactions from %0d commands and ticks, %0d travel writes.",
                 results_checked, items_sent, travel_writes);
        $display("Idle patterns covered: none, sender gaps, receiver stalls, both; %0d mismatches.",
                 mismatch_count);
        if (total_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
